// ----- design/i2c_seq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C sequencer package
// Opcodes, field widths and the result record shared by the sequencer files.
// ----------------------------------------------------------------------------
package i2c_seq_pkg;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 5;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_SACK  = 3'd5;
    localparam logic [OP_W-1:0] OP_RACK  = 3'd6;

    // last action numbers
    localparam logic [IDX_W-1:0] START_LAST = 5'd3;
    localparam logic [IDX_W-1:0] STOP_LAST  = 5'd2;
    localparam logic [IDX_W-1:0] WRITE_LAST = 5'(3 * BYTE_W - 1);
    localparam logic [IDX_W-1:0] READ_LAST  = 5'(3 * BYTE_W);
    localparam logic [IDX_W-1:0] SACK_LAST  = 5'd2;
    localparam logic [IDX_W-1:0] RACK_LAST  = 5'd3;

    // phase within one bit slot
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
        logic              rejected;
    } result_t;

endpackage

// ----- design/i2c_seq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C sequencer channels
// Valid/ready interfaces for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface i2c_seq_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [i2c_seq_pkg::OP_W-1:0]    opcode;
    logic [i2c_seq_pkg::BYTE_W-1:0]  tx_byte;
    logic                            ack_value;
    logic                            sda_in;

    modport source (output valid, opcode, tx_byte, ack_value, sda_in, input ready);
    modport sink   (input valid, opcode, tx_byte, ack_value, sda_in, output ready);
endinterface

interface i2c_seq_res_if;
    logic                            valid;
    logic                            ready;
    logic                            scl_out;
    logic                            sda_out;
    logic                            done_res;
    logic [i2c_seq_pkg::BYTE_W-1:0]  rx_byte;
    logic                            ack_seen;
    logic                            rejected;

    modport source (output valid, scl_out, sda_out, done_res, rx_byte, ack_seen, rejected,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, done_res, rx_byte, ack_seen, rejected,
                    output ready);
endinterface

// ----- design/i2c_master_bit_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Steps open-drain SCL/SDA levels through start, stop, byte and ack actions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake     | payload
//  cmd     | in        | valid / ready | opcode, tx_byte, ack_value, sda_in
//  res     | out       | valid / ready | scl_out, sda_out, done_res, rx_byte,
//          |           |               | ack_seen, rejected
//
//  One command transaction per clock while cmd.ready is high; each yields one result.
//  Sequencer state and next-action logic sit in one registered pass.
//  Results land in an output register backed by a one-entry skid stage, so
//  cmd.ready only drops while the skid stage is full.
//  rst_n (async, low) returns to idle with both lines released high.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    i2c_seq_cmd_if.sink          cmd,
    i2c_seq_res_if.source        res
);

    // one-hot command state; IDLE when no command is running
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_STOP  = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_SACK  = 7'b0100000,
        ST_RACK  = 7'b1000000
    } cmd_state_t;

    cmd_state_t                          state_reg, state_next, state_load;
    logic [i2c_seq_pkg::IDX_W-1:0]       idx_reg, idx_next, idx_cur;
    logic [1:0]                          phase_reg, phase_next, phase_cur;
    logic [i2c_seq_pkg::BYTE_W-1:0]      send_reg, send_next;
    logic [i2c_seq_pkg::BYTE_W-1:0]      recv_reg, recv_next;
    logic                                ack_reg, ack_next;
    logic                                scl_reg, scl_next;
    logic                                sda_reg, sda_next;

    i2c_seq_pkg::result_t                out_reg, skid_reg, result;
    logic                                out_valid_reg, skid_valid_reg;

    logic cmd_fire, res_fire, is_cmd, load, act, last;
    cmd_state_t active;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign res_fire  = res.valid && res.ready;
    assign cmd.ready = !skid_valid_reg;

    assign is_cmd = (cmd.opcode >= i2c_seq_pkg::OP_START) &&
                    (cmd.opcode <= i2c_seq_pkg::OP_RACK);

    // opcode decoder
    always_comb
    begin
        unique case (cmd.opcode)
            i2c_seq_pkg::OP_START: state_load = ST_START;
            i2c_seq_pkg::OP_STOP:  state_load = ST_STOP;
            i2c_seq_pkg::OP_WRITE: state_load = ST_WRITE;
            i2c_seq_pkg::OP_READ:  state_load = ST_READ;
            i2c_seq_pkg::OP_SACK:  state_load = ST_SACK;
            i2c_seq_pkg::OP_RACK:  state_load = ST_RACK;
            default:               state_load = ST_IDLE;
        endcase
    end

    always_comb
    begin
        load = cmd_fire && is_cmd && (state_reg == ST_IDLE);
        act  = load || (cmd_fire && (cmd.opcode == i2c_seq_pkg::OP_TICK) &&
                        (state_reg != ST_IDLE));

        // a loaded command acts on its fresh context in the same pass
        active    = load ? state_load : state_reg;
        idx_cur   = load ? '0 : idx_reg;
        phase_cur = load ? i2c_seq_pkg::PH_DATA : phase_reg;
        send_next = (load && state_load == ST_WRITE) ? cmd.tx_byte : send_reg;
        recv_next = (load && state_load == ST_READ) ? '0 : recv_reg;
        ack_next  = (load && state_load == ST_SACK) ? cmd.ack_value : ack_reg;

        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        last       = 1'b0;

        if (act)
        begin
            unique case (active)
                ST_START:
                begin
                    unique case (idx_cur)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                    last = (idx_cur >= i2c_seq_pkg::START_LAST);
                end
                ST_STOP:
                begin
                    unique case (idx_cur)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                    last = (idx_cur >= i2c_seq_pkg::STOP_LAST);
                end
                ST_WRITE:
                begin
                    case (phase_cur)
                        i2c_seq_pkg::PH_DATA:
                        begin
                            sda_next  = send_next[i2c_seq_pkg::BYTE_W-1];
                            send_next = {send_next[i2c_seq_pkg::BYTE_W-2:0], 1'b0};
                        end
                        i2c_seq_pkg::PH_HIGH: scl_next = 1'b1;
                        default:              scl_next = 1'b0;
                    endcase
                    phase_next = (phase_cur == i2c_seq_pkg::PH_LOW) ?
                                 i2c_seq_pkg::PH_DATA : phase_cur + 2'd1;
                    last = (idx_cur >= i2c_seq_pkg::WRITE_LAST);
                end
                ST_READ:
                begin
                    // release SDA first, then three-action bit slots
                    if (idx_cur == '0)
                    begin
                        sda_next   = 1'b1;
                        phase_next = i2c_seq_pkg::PH_DATA;
                    end
                    else
                    begin
                        case (phase_cur)
                            i2c_seq_pkg::PH_DATA: scl_next = 1'b1;
                            i2c_seq_pkg::PH_HIGH:
                                recv_next = {recv_next[i2c_seq_pkg::BYTE_W-2:0], cmd.sda_in};
                            default:              scl_next = 1'b0;
                        endcase
                        phase_next = (phase_cur == i2c_seq_pkg::PH_LOW) ?
                                     i2c_seq_pkg::PH_DATA : phase_cur + 2'd1;
                    end
                    last = (idx_cur >= i2c_seq_pkg::READ_LAST);
                end
                ST_SACK:
                begin
                    unique case (idx_cur)
                        5'd0:    sda_next = ack_next;
                        5'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                    last = (idx_cur >= i2c_seq_pkg::SACK_LAST);
                end
                ST_RACK:
                begin
                    unique case (idx_cur)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    ack_next = cmd.sda_in;
                        default: scl_next = 1'b0;
                    endcase
                    last = (idx_cur >= i2c_seq_pkg::RACK_LAST);
                end
                default: last = 1'b1;
            endcase

            if (last)
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
                phase_next = i2c_seq_pkg::PH_DATA;
            end
            else
            begin
                state_next = active;
                idx_next   = idx_cur + 5'd1;
            end
        end

        result.scl_out  = scl_next;
        result.sda_out  = sda_next;
        result.done_res = act && last;
        result.rx_byte  = (act && last && active == ST_READ) ? recv_next : '0;
        result.ack_seen = act && last && (active == ST_RACK) && ack_next;
        result.rejected = cmd_fire && is_cmd && (state_reg != ST_IDLE);
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            phase_reg <= i2c_seq_pkg::PH_DATA;
            send_reg  <= '0;
            recv_reg  <= '0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
        end
        else if (cmd_fire)
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            send_reg  <= send_next;
            recv_reg  <= recv_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (cmd_fire)
        begin
            if (out_valid_reg && !res.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (res_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (res_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (cmd_fire)
        begin
            if (out_valid_reg && !res.ready)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.scl_out  = out_reg.scl_out;
    assign res.sda_out  = out_reg.sda_out;
    assign res.done_res = out_reg.done_res;
    assign res.rx_byte  = out_reg.rx_byte;
    assign res.ack_seen = out_reg.ack_seen;
    assign res.rejected = out_reg.rejected;

    // checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (idx_reg == '0))
        else $error("action index not cleared in idle");

    a_reject_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.rejected && out_reg.done_res))
        else $error("result both rejected and done");

    a_rx_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.rx_byte != '0 || out_reg.ack_seen)) |-> out_reg.done_res)
        else $error("read data reported without done");

    a_reject_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && is_cmd && state_reg != ST_IDLE) |=> $stable(idx_reg))
        else $error("rejected command advanced the sequence");

endmodule

// ----- verif/tb_i2c_master_bit_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives command and tick transactions into the sequencer and predicts the
// SCL/SDA levels, done flag, read byte, ack sample and reject flag of every
// result. Runs directed line operations and busy rejects, then random
// well-formed operations with noise, under sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer_top;

    // Opcode seven has no meaning in the package; the sequencer ignores it.
    localparam logic [i2c_seq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    // SDA sources for the tick transactions of one operation
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    logic clk;
    logic rst_n;

    i2c_seq_cmd_if cmd_bus ();
    i2c_seq_res_if res_bus ();

    i2c_master_bit_sequencer_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    // ------------------------------------------------------------------------
    // Line state as the sequencer should hold it after every accepted
    // transaction. Updated at the clock edge that accepts a transaction.
    // ------------------------------------------------------------------------
    logic [i2c_seq_pkg::OP_W-1:0]   line_op;
    logic [i2c_seq_pkg::IDX_W-1:0]  line_step;
    logic [i2c_seq_pkg::BYTE_W-1:0] line_tx_shift;
    logic [i2c_seq_pkg::BYTE_W-1:0] line_rx_shift;
    logic                           line_ack;
    logic                           line_scl;
    logic                           line_sda;

    i2c_seq_pkg::result_t line_results_q[$];   // predicted results, oldest first

    int mismatches   = 0;
    int cmd_accepted = 0;
    int send_idle_pct  = 0;       // chance per cycle that the sender idles
    int recv_stall_pct = 0;       // chance per cycle that the receiver stalls
    int recv_hold_left = 0;       // long receiver hold-off, counted down below

    // ------------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #(64'd5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: one accepted transaction in, one result out.
    // ------------------------------------------------------------------------
    function automatic i2c_seq_pkg::result_t predict_line(
        input logic [i2c_seq_pkg::OP_W-1:0]   op,
        input logic [i2c_seq_pkg::BYTE_W-1:0] tx,
        input logic                           ackv,
        input logic                           sda_smp);
        i2c_seq_pkg::result_t r;
        logic                 acts;
        logic                 is_last;
        logic [1:0]           ph;
        r       = '0;
        acts    = 1'b0;
        is_last = 1'b0;

        if (op != i2c_seq_pkg::OP_TICK && op != OP_UNUSED)
        begin
            if (line_op != i2c_seq_pkg::OP_TICK)
                r.rejected = 1'b1;        // command while busy: nothing moves
            else
            begin
                line_op   = op;
                line_step = '0;
                if (op == i2c_seq_pkg::OP_WRITE) line_tx_shift = tx;
                if (op == i2c_seq_pkg::OP_READ)  line_rx_shift = '0;
                if (op == i2c_seq_pkg::OP_SACK)  line_ack      = ackv;
                acts = 1'b1;
            end
        end
        else if (op == i2c_seq_pkg::OP_TICK && line_op != i2c_seq_pkg::OP_TICK)
            acts = 1'b1;

        if (acts)
        begin
            case (line_op)
                i2c_seq_pkg::OP_START:
                begin
                    case (line_step)
                        5'd0:    line_sda = 1'b1;
                        5'd1:    line_scl = 1'b1;
                        5'd2:    line_sda = 1'b0;
                        default: line_scl = 1'b0;
                    endcase
                    is_last = (line_step >= i2c_seq_pkg::START_LAST);
                end
                i2c_seq_pkg::OP_STOP:
                begin
                    case (line_step)
                        5'd0:    line_sda = 1'b0;
                        5'd1:    line_scl = 1'b1;
                        default: line_sda = 1'b1;
                    endcase
                    is_last = (line_step >= i2c_seq_pkg::STOP_LAST);
                end
                i2c_seq_pkg::OP_WRITE:
                begin
                    ph = 2'(line_step % 5'd3);
                    if (ph == i2c_seq_pkg::PH_DATA)
                    begin
                        line_sda      = line_tx_shift[i2c_seq_pkg::BYTE_W-1];
                        line_tx_shift = {line_tx_shift[i2c_seq_pkg::BYTE_W-2:0], 1'b0};
                    end
                    else if (ph == i2c_seq_pkg::PH_HIGH)
                        line_scl = 1'b1;
                    else
                        line_scl = 1'b0;
                    is_last = (line_step >= i2c_seq_pkg::WRITE_LAST);
                end
                i2c_seq_pkg::OP_READ:
                begin
                    if (line_step == '0)
                        line_sda = 1'b1;
                    else
                    begin
                        ph = 2'((line_step - 5'd1) % 5'd3);
                        if (ph == i2c_seq_pkg::PH_DATA)
                            line_scl = 1'b1;
                        else if (ph == i2c_seq_pkg::PH_HIGH)
                            line_rx_shift = {line_rx_shift[i2c_seq_pkg::BYTE_W-2:0], sda_smp};
                        else
                            line_scl = 1'b0;
                    end
                    is_last = (line_step >= i2c_seq_pkg::READ_LAST);
                end
                i2c_seq_pkg::OP_SACK:
                begin
                    case (line_step)
                        5'd0:    line_sda = line_ack;
                        5'd1:    line_scl = 1'b1;
                        default: line_scl = 1'b0;
                    endcase
                    is_last = (line_step >= i2c_seq_pkg::SACK_LAST);
                end
                i2c_seq_pkg::OP_RACK:
                begin
                    case (line_step)
                        5'd0:    line_sda = 1'b1;
                        5'd1:    line_scl = 1'b1;
                        5'd2:    line_ack = sda_smp;
                        default: line_scl = 1'b0;
                    endcase
                    is_last = (line_step >= i2c_seq_pkg::RACK_LAST);
                end
                default: is_last = 1'b1;
            endcase

            if (is_last)
            begin
                r.done_res = 1'b1;
                if (line_op == i2c_seq_pkg::OP_READ) r.rx_byte  = line_rx_shift;
                if (line_op == i2c_seq_pkg::OP_RACK) r.ack_seen = line_ack;
                line_op   = i2c_seq_pkg::OP_TICK;
                line_step = '0;
            end
            else
                line_step = line_step + 5'd1;
        end

        r.scl_out = line_scl;
        r.sda_out = line_sda;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: entered just after a rising edge (or at the start), drives at
    // the falling edge and returns at the rising edge that accepts the
    // transaction. Valid is left high so back-to-back offers never drop it.
    // ------------------------------------------------------------------------
    task automatic offer_txn(input logic [i2c_seq_pkg::OP_W-1:0]   op,
                             input logic [i2c_seq_pkg::BYTE_W-1:0] tx,
                             input logic ackv, input logic sda_smp);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid     = 1'b1;
        cmd_bus.opcode    = op;
        cmd_bus.tx_byte   = tx;
        cmd_bus.ack_value = ackv;
        cmd_bus.sda_in    = sda_smp;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        line_results_q.push_back(predict_line(op, tx, ackv, sda_smp));
        cmd_accepted++;
    endtask

    task automatic go_quiet;
        @(negedge clk);
        cmd_bus.valid = 1'b0;
    endtask

    // Sender pauses until every predicted result has been collected.
    task automatic drain_results;
        go_quiet();
        while (line_results_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic pick_sda(input int sda_src);
        if (sda_src == SDA_RAND)
            return 1'($urandom_range(1));
        return (sda_src == SDA_HIGH);
    endfunction

    // One line operation: the command, then ticks until the predictor sees it
    // finish. noise_pct of the ticks are swapped for a busy command or opcode 7.
    task automatic run_line_op(input logic [i2c_seq_pkg::OP_W-1:0]   op,
                               input logic [i2c_seq_pkg::BYTE_W-1:0] tx,
                               input logic ackv, input int sda_src, input int noise_pct);
        offer_txn(op, tx, ackv, pick_sda(sda_src));
        while (line_op != i2c_seq_pkg::OP_TICK)
        begin
            if ($urandom_range(99) < noise_pct)
                offer_txn(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else
                offer_txn(i2c_seq_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(1)),
                          pick_sda(sda_src));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready changes at the falling edge. A long hold-off, when
    // requested, is counted down here before random stalling resumes.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            res_bus.ready  = 1'b0;
            recv_hold_left = recv_hold_left - 1;
        end
        else
            res_bus.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name,
                               input logic [i2c_seq_pkg::BYTE_W-1:0] want,
                               input logic [i2c_seq_pkg::BYTE_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        i2c_seq_pkg::result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (line_results_q.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result expected none, got scl %b sda %b done %b",
                         $time, res_bus.scl_out, res_bus.sda_out, res_bus.done_res);
            end
            else
            begin
                want = line_results_q.pop_front();
                check_field("scl_out",  want.scl_out,  res_bus.scl_out);
                check_field("sda_out",  want.sda_out,  res_bus.sda_out);
                check_field("done_res", want.done_res, res_bus.done_res);
                check_field("rx_byte",  want.rx_byte,  res_bus.rx_byte);
                check_field("ack_seen", want.ack_seen, res_bus.ack_seen);
                check_field("rejected", want.rejected, res_bus.rejected);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ticks and opcode 7 while idle: nothing moves, lines stay released.
    task automatic test_idle_ignored;
        offer_txn(i2c_seq_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
        offer_txn(i2c_seq_pkg::OP_TICK, 8'hFF, 1'b1, 1'b1);
        offer_txn(OP_UNUSED,            8'hFF, 1'b1, 1'b1);
        offer_txn(OP_UNUSED,            8'h00, 1'b0, 1'b0);
    endtask

    // Every operation at least once, with the byte and ack extremes.
    task automatic test_each_operation;
        run_line_op(i2c_seq_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 0);
        run_line_op(i2c_seq_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_LOW,  0);
        run_line_op(i2c_seq_pkg::OP_WRITE, 8'h00, 1'b1, SDA_HIGH, 0);
        run_line_op(i2c_seq_pkg::OP_RACK,  8'h00, 1'b0, SDA_LOW,  0);
        run_line_op(i2c_seq_pkg::OP_RACK,  8'hFF, 1'b1, SDA_HIGH, 0);
        run_line_op(i2c_seq_pkg::OP_READ,  8'h00, 1'b0, SDA_HIGH, 0);
        run_line_op(i2c_seq_pkg::OP_READ,  8'hFF, 1'b1, SDA_LOW,  0);
        run_line_op(i2c_seq_pkg::OP_SACK,  8'hFF, 1'b0, SDA_RAND, 0);
        run_line_op(i2c_seq_pkg::OP_SACK,  8'h00, 1'b1, SDA_RAND, 0);
        run_line_op(i2c_seq_pkg::OP_STOP,  8'hFF, 1'b1, SDA_RAND, 0);
    endtask

    // Every command while busy is rejected; opcode 7 is ignored.
    task automatic test_busy_rejects;
        logic [i2c_seq_pkg::OP_W-1:0] op;
        offer_txn(i2c_seq_pkg::OP_START, 8'h00, 1'b0, 1'b0);
        for (int k = 1; k <= 7; k++)
        begin
            op = 3'(k);
            offer_txn(op, 8'hA5, 1'b1, 1'b1);
        end
        while (line_op != i2c_seq_pkg::OP_TICK)
            offer_txn(i2c_seq_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
    endtask

    // Random well-formed operations, with some busy commands and idle noise.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int target;
        target         = cmd_accepted + n_items;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (cmd_accepted < target)
        begin
            if ($urandom_range(99) < 8)
                offer_txn($urandom_range(1) ? i2c_seq_pkg::OP_TICK : OP_UNUSED,
                          8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                run_line_op(3'($urandom_range(6, 1)), 8'($urandom), 1'($urandom_range(1)),
                            SDA_RAND, 10);
        end
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the output register and skid stage fill and cmd.ready drops.
    task automatic test_output_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_left = 200;
        run_line_op(i2c_seq_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 0);
        run_line_op(i2c_seq_pkg::OP_WRITE, 8'($urandom), 1'b0, SDA_RAND, 0);
        run_line_op(i2c_seq_pkg::OP_RACK,  8'h00, 1'b0, SDA_RAND, 0);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        line_op       = i2c_seq_pkg::OP_TICK;
        line_step     = '0;
        line_tx_shift = '0;
        line_rx_shift = '0;
        line_ack      = 1'b0;
        line_scl      = 1'b1;
        line_sda      = 1'b1;

        rst_n             = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.opcode    = i2c_seq_pkg::OP_TICK;
        cmd_bus.tx_byte   = '0;
        cmd_bus.ack_value = 1'b0;
        cmd_bus.sda_in    = 1'b0;
        res_bus.ready     = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_idle_ignored();
        test_each_operation();
        test_busy_rejects();
        drain_results();

        test_random_traffic(0,  0,  100);
        test_random_traffic(75, 0,  85);
        test_random_traffic(0,  75, 85);
        test_random_traffic(16, 16, 90);
        test_output_backpressure();

        // every prediction collected; allow the output stages to settle
        go_quiet();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && line_results_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
